>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

>>> hw/rtl/rrq_pkg.sv
// Types and constants of the request retry queue controller.
package rrq_pkg;

    localparam int QLEN_W      = 5;
    localparam int TRIES_W     = 4;
    localparam int TIMEOUT_W   = 16;
    localparam int TOTAL_W     = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int ACTION_W    = 3;

    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = 2;
    localparam int OFIFO_CNT_W = 3;

    localparam logic [QLEN_W-1:0]    MAX_QUEUE_LEN_RST = 5'd16;
    localparam logic [TRIES_W-1:0]   MAX_RETRIES_RST   = 4'd3;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;

    localparam logic [TIMEOUT_W-1:0] WAIT_MAX  = 16'hFFFF;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX = 20'hFFFFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_QUEUE_LEN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RETRIES   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ENQ    = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_REPLY  = 2'd3
    } kind_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACCEPTED  = 3'd0,
        ACT_DROPPED   = 3'd1,
        ACT_SEND_REQ  = 3'd2,
        ACT_RECONNECT = 3'd3,
        ACT_REPLY     = 3'd4,
        ACT_GAVE_UP   = 3'd5,
        ACT_SENT      = 3'd6
    } action_t;

    typedef struct packed {
        logic shift;
        logic load;
    } rrq_cell_ctl_t;

endpackage

>>> hw/rtl/rrq_cell.sv
// Queue cell: holds a word; pop takes the neighbor's, load takes new data.
module rrq_cell
    import rrq_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  rrq_cell_ctl_t    ctl,
    input  logic [WIDTH-1:0] from_next,
    input  logic [WIDTH-1:0] load_data,
    output logic [WIDTH-1:0] data
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift)
        begin
            data_next = from_next;
        end
        else if (ctl.load)
        begin
            data_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> hw/rtl/rrq_out_fifo.sv
// Result buffer: takes up to two results per cycle, hands out one per transfer.
module rrq_out_fifo
    import rrq_pkg::*;
#(
    parameter int WIDTH = 92
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       wr_num,
    input  logic [WIDTH-1:0] wr_data0,
    input  logic [WIDTH-1:0] wr_data1,
    output logic             rd_valid,
    input  logic             rd_stall,
    output logic [WIDTH-1:0] rd_data,
    output logic             no_room
);

    logic [WIDTH-1:0]       mem [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] wr_ptr_reg;
    logic [OFIFO_PTR_W-1:0] wr_ptr_next;
    logic [OFIFO_PTR_W-1:0] rd_ptr_reg;
    logic [OFIFO_PTR_W-1:0] rd_ptr_next;
    logic [OFIFO_CNT_W-1:0] count_reg;
    logic [OFIFO_CNT_W-1:0] count_next;
    logic                   pop;

    assign rd_valid = (count_reg != '0);
    assign pop      = rd_valid && !rd_stall;
    assign rd_data  = mem[rd_ptr_reg];
    assign no_room  = (count_reg > OFIFO_CNT_W'(OFIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OFIFO_PTR_W'(wr_num);
        rd_ptr_next = rd_ptr_reg + OFIFO_PTR_W'(pop);
        count_next  = count_reg + OFIFO_CNT_W'(wr_num) - OFIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr_num != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr_data0;
        end
        if (wr_num == 2'd2)
        begin
            mem[wr_ptr_reg + OFIFO_PTR_W'(1)] <= wr_data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/request_retry_queue_controller.sv
// Top level: payload queue of cells, send/retry state machine, result buffer.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | kind, payload, send_ok, reply_data
//  out     | output    | out_valid/out_stall| action, out_payload, out_reply,
//          |           |                    | tries_used, elapsed_ticks, last
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item per cycle unless stalled; results enter the buffer at the same edge.
//  From an empty buffer a result is on out the cycle after its input transfer.
//  in_stall rises when the four-entry result buffer holds more than two results.
//  A queue pop shifts every cell toward the head together.
//  Reset clears state and counters, loads config defaults; cells are not cleared.
module request_retry_queue_controller
    import rrq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int REPLY_WIDTH   = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               kind,
    input  logic [PAYLOAD_WIDTH-1:0] payload,
    input  logic                     send_ok,
    input  logic [REPLY_WIDTH-1:0]   reply_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ACTION_W-1:0]      action,
    output logic [PAYLOAD_WIDTH-1:0] out_payload,
    output logic [REPLY_WIDTH-1:0]   out_reply,
    output logic [TRIES_W-1:0]       tries_used,
    output logic [TOTAL_W-1:0]       elapsed_ticks,
    output logic                     last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

`include "assert_macros.svh"

    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int LW    = (CW > QLEN_W) ? CW : QLEN_W;
    localparam int RES_W = ACTION_W + PAYLOAD_WIDTH + REPLY_WIDTH + TRIES_W + TOTAL_W + 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

    logic [QLEN_W-1:0]    max_queue_len_reg;
    logic [TRIES_W-1:0]   max_retries_reg;
    logic [TIMEOUT_W-1:0] timeout_ticks_reg;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [TRIES_W-1:0]   tries_left_reg;
    logic [TRIES_W-1:0]   tries_left_next;
    logic [TIMEOUT_W-1:0] wait_reg;
    logic [TIMEOUT_W-1:0] wait_next;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [PAYLOAD_WIDTH-1:0] cur_payload_reg;
    logic [PAYLOAD_WIDTH-1:0] cur_payload_next;
    logic [CW-1:0]        fifo_count_reg;
    logic [CW-1:0]        fifo_count_next;

    logic                 in_accept;
    logic                 push;
    logic                 pop;
    logic [LW-1:0]        limit;
    logic [LW-1:0]        qlen_ext;
    logic                 can_push;
    logic [TRIES_W-1:0]   eff_retries;
    logic [TRIES_W-1:0]   used;
    logic [TOTAL_W-1:0]   total_inc;

    logic [1:0]               res_num;
    action_t                  act0;
    action_t                  act1;
    logic [PAYLOAD_WIDTH-1:0] pay0;
    logic [PAYLOAD_WIDTH-1:0] pay1;
    logic [REPLY_WIDTH-1:0]   rep0;
    logic [TRIES_W-1:0]       tries0;
    logic [TOTAL_W-1:0]       el0;
    logic [TOTAL_W-1:0]       el1;
    logic [RES_W-1:0]         res_data0;
    logic [RES_W-1:0]         res_data1;
    logic [RES_W-1:0]         rd_data;
    logic                     ofifo_no_room;

    logic [PAYLOAD_WIDTH-1:0] cell_data [QUEUE_DEPTH];
    rrq_cell_ctl_t            cell_ctl  [QUEUE_DEPTH];

    assign in_stall  = ofifo_no_room;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_queue_len_reg <= MAX_QUEUE_LEN_RST;
            max_retries_reg   <= MAX_RETRIES_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_QUEUE_LEN: max_queue_len_reg <= cfg_data[QLEN_W-1:0];
                CFG_MAX_RETRIES:   max_retries_reg   <= cfg_data[TRIES_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TIMEOUT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Payload queue: cell 0 is the head.
    generate
        for (genvar i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic [PAYLOAD_WIDTH-1:0] from_next;

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign from_next = '0;
            end
            else
            begin : g_mid
                assign from_next = cell_data[i+1];
            end

            assign cell_ctl[i].shift = pop;
            assign cell_ctl[i].load  = push && (fifo_count_reg == CW'(i));

            rrq_cell #(
                .WIDTH(PAYLOAD_WIDTH)
            ) u_cell (
                .clk      (clk),
                .ctl      (cell_ctl[i]),
                .from_next(from_next),
                .load_data(payload),
                .data     (cell_data[i])
            );
        end
    endgenerate

    assign qlen_ext    = LW'(max_queue_len_reg);
    assign limit       = (qlen_ext > DEPTH_L) ? DEPTH_L : qlen_ext;
    assign can_push    = (LW'(fifo_count_reg) < limit);
    assign eff_retries = (max_retries_reg == '0) ? TRIES_W'(1) : max_retries_reg;
    assign used        = (eff_retries > tries_left_reg) ? (eff_retries - tries_left_reg) : '0;
    assign total_inc   = (total_reg == TOTAL_MAX) ? total_reg : (total_reg + TOTAL_W'(1));

    always_comb
    begin
        phase_next       = phase_reg;
        tries_left_next  = tries_left_reg;
        wait_next        = wait_reg;
        total_next       = total_reg;
        cur_payload_next = cur_payload_reg;
        fifo_count_next  = fifo_count_reg;
        push             = 1'b0;
        pop              = 1'b0;
        res_num          = 2'd0;
        act0             = ACT_ACCEPTED;
        act1             = ACT_ACCEPTED;
        pay0             = '0;
        pay1             = '0;
        rep0             = '0;
        tries0           = '0;
        el0              = '0;
        el1              = '0;
        if (in_accept)
        begin
            case (kind_t'(kind))
                KIND_ENQ:
                begin
                    res_num = 2'd1;
                    if (can_push)
                    begin
                        push            = 1'b1;
                        fifo_count_next = fifo_count_reg + CW'(1);
                        act0            = ACT_ACCEPTED;
                    end
                    else
                    begin
                        act0 = ACT_DROPPED;
                    end
                end
                KIND_TICK:
                begin
                    case (phase_reg)
                        PH_SEND:
                        begin
                            total_next = total_inc;
                        end
                        PH_WAIT:
                        begin
                            total_next = total_inc;
                            if (wait_reg >= timeout_ticks_reg)
                            begin
                                res_num   = 2'd2;
                                act0      = ACT_RECONNECT;
                                wait_next = '0;
                                pay1      = cur_payload_reg;
                                if (tries_left_reg == '0)
                                begin
                                    phase_next = PH_IDLE;
                                    act1       = ACT_GAVE_UP;
                                    el1        = total_inc;
                                end
                                else
                                begin
                                    tries_left_next = tries_left_reg - TRIES_W'(1);
                                    phase_next      = PH_SEND;
                                    act1            = ACT_SEND_REQ;
                                end
                            end
                            else if (wait_reg != WAIT_MAX)
                            begin
                                wait_next = wait_reg + TIMEOUT_W'(1);
                            end
                        end
                        default:
                        begin
                            if (fifo_count_reg != '0)
                            begin
                                pop              = 1'b1;
                                fifo_count_next  = fifo_count_reg - CW'(1);
                                cur_payload_next = cell_data[0];
                                tries_left_next  = eff_retries - TRIES_W'(1);
                                total_next       = '0;
                                wait_next        = '0;
                                phase_next       = PH_SEND;
                                res_num          = 2'd1;
                                act0             = ACT_SEND_REQ;
                                pay0             = cell_data[0];
                            end
                        end
                    endcase
                end
                KIND_STATUS:
                begin
                    if (phase_reg == PH_SEND)
                    begin
                        res_num = 2'd1;
                        if (send_ok)
                        begin
                            phase_next = PH_WAIT;
                            wait_next  = '0;
                            act0       = ACT_SENT;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            act0       = ACT_RECONNECT;
                        end
                    end
                end
                KIND_REPLY:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        phase_next = PH_IDLE;
                        res_num    = 2'd1;
                        act0       = ACT_REPLY;
                        rep0       = reply_data;
                        tries0     = used;
                        el0        = total_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tries_left_reg  <= '0;
            wait_reg        <= '0;
            total_reg       <= '0;
            cur_payload_reg <= '0;
            fifo_count_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            tries_left_reg  <= tries_left_next;
            wait_reg        <= wait_next;
            total_reg       <= total_next;
            cur_payload_reg <= cur_payload_next;
            fifo_count_reg  <= fifo_count_next;
        end
    end

    assign res_data0 = {act0, pay0, rep0, tries0, el0, (res_num == 2'd1)};
    assign res_data1 = {act1, pay1, {REPLY_WIDTH{1'b0}}, {TRIES_W{1'b0}}, el1, 1'b1};

    rrq_out_fifo #(
        .WIDTH(RES_W)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_num  (res_num),
        .wr_data0(res_data0),
        .wr_data1(res_data1),
        .rd_valid(out_valid),
        .rd_stall(out_stall),
        .rd_data (rd_data),
        .no_room (ofifo_no_room)
    );

    assign {action, out_payload, out_reply, tries_used, elapsed_ticks, last} = rd_data;

    `ASSERT_NEVER(a_count_bound, fifo_count_reg > CW'(QUEUE_DEPTH), "queue count above depth")
    `ASSERT_CLK(a_out_drain, $fell(out_valid) |-> $past(out_valid && !out_stall), "result lost")
    `ASSERT_CLK(a_pop_count, pop |=> (fifo_count_reg == $past(fifo_count_reg) - CW'(1)), "bad pop")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the request retry queue controller: directed table, then random traffic.
module tb_top
    import rrq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CHK_MODEL = 2'd0;
    localparam logic [1:0] CHK_NONE  = 2'd1;
    localparam logic [1:0] CHK_TYPED = 2'd2;
    localparam int         DEPTH     = 16;

    typedef struct packed {
        action_t       act;
        logic [31:0]   pay;
        logic [31:0]   rep;
        logic [3:0]    tries;
        logic [19:0]   elapsed;
        logic          fin;
    } outcome_t;

    typedef struct packed {
        logic          is_cfg;
        logic [1:0]    idx;
        logic [15:0]   val;
        kind_t         k;
        logic [31:0]   pay;
        logic          ok;
        logic [31:0]   rep;
        logic [1:0]    mode;
        action_t       act;
        logic [31:0]   want_pay;
    } script_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                kind;
    logic [31:0]               payload;
    logic                      send_ok;
    logic [31:0]               reply_data;
    logic                      out_valid;
    logic                      out_stall;
    logic [ACTION_W-1:0]       action;
    logic [31:0]               out_payload;
    logic [31:0]               out_reply;
    logic [TRIES_W-1:0]        tries_used;
    logic [TOTAL_W-1:0]        elapsed_ticks;
    logic                      last;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    logic [4:0]                lim_qlen;
    logic [3:0]                lim_retries;
    logic [15:0]               lim_timeout;
    phase_t                    mdl_phase;
    logic [4:0]                mdl_tries_left;
    logic [15:0]               mdl_wait;
    logic [19:0]               mdl_total;
    logic [31:0]               mdl_current;
    logic [31:0]               backlog[$];

    outcome_t                  step_out[$];
    outcome_t                  pending[$];
    script_row_t               script[$];
    int                        faults;
    bit                        send_calm;
    bit                        recv_calm;

    request_retry_queue_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .payload       (payload),
        .send_ok       (send_ok),
        .reply_data    (reply_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .action        (action),
        .out_payload   (out_payload),
        .out_reply     (out_reply),
        .tries_used    (tries_used),
        .elapsed_ticks (elapsed_ticks),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic log_fault(input string msg);
        faults++;
        if (faults <= 60)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_fault($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic outcome_t make_outcome(input action_t a, input logic [31:0] p,
                                              input logic [31:0] r, input logic [3:0] t,
                                              input logic [19:0] e);
        outcome_t o;
        o.act = a;
        o.pay = p;
        o.rep = r;
        o.tries = t;
        o.elapsed = e;
        o.fin = 1'b0;
        return o;
    endfunction

    task automatic predict_event(input kind_t k, input logic [31:0] p, input logic ok,
                                 input logic [31:0] r);
        int unsigned limit;
        logic [4:0]  eff;
        logic [4:0]  used;
        step_out.delete();
        eff = (lim_retries == 4'd0) ? 5'd1 : {1'b0, lim_retries};
        case (k)
            KIND_ENQ:
            begin
                limit = (lim_qlen > DEPTH) ? DEPTH : lim_qlen;
                if (backlog.size() < limit)
                begin
                    backlog.insert(backlog.size(), p);
                    step_out.insert(step_out.size(),
                                    make_outcome(ACT_ACCEPTED, '0, '0, '0, '0));
                end
                else
                    step_out.insert(step_out.size(),
                                    make_outcome(ACT_DROPPED, '0, '0, '0, '0));
            end
            KIND_TICK:
            begin
                if (mdl_phase == PH_IDLE)
                begin
                    if (backlog.size() > 0)
                    begin
                        mdl_current = backlog.pop_front();
                        mdl_tries_left = eff - 5'd1;
                        mdl_total = '0;
                        mdl_wait = '0;
                        mdl_phase = PH_SEND;
                        step_out.insert(step_out.size(),
                                        make_outcome(ACT_SEND_REQ, mdl_current, '0, '0, '0));
                    end
                end
                else
                begin
                    if (mdl_total != TOTAL_MAX)
                        mdl_total = mdl_total + 20'd1;
                    if (mdl_phase == PH_WAIT)
                    begin
                        if (mdl_wait >= lim_timeout)
                        begin
                            step_out.insert(step_out.size(),
                                            make_outcome(ACT_RECONNECT, '0, '0, '0, '0));
                            mdl_wait = '0;
                            if (mdl_tries_left == 5'd0)
                            begin
                                mdl_phase = PH_IDLE;
                                step_out.insert(step_out.size(),
                                                make_outcome(ACT_GAVE_UP, mdl_current, '0, '0,
                                                             mdl_total));
                            end
                            else
                            begin
                                mdl_tries_left = mdl_tries_left - 5'd1;
                                mdl_phase = PH_SEND;
                                step_out.insert(step_out.size(),
                                                make_outcome(ACT_SEND_REQ, mdl_current, '0, '0,
                                                             '0));
                            end
                        end
                        else if (mdl_wait != WAIT_MAX)
                            mdl_wait = mdl_wait + 16'd1;
                    end
                end
            end
            KIND_STATUS:
            begin
                if (mdl_phase == PH_SEND)
                begin
                    if (ok)
                    begin
                        mdl_phase = PH_WAIT;
                        mdl_wait = '0;
                        step_out.insert(step_out.size(),
                                        make_outcome(ACT_SENT, '0, '0, '0, '0));
                    end
                    else
                    begin
                        mdl_phase = PH_IDLE;
                        step_out.insert(step_out.size(),
                                        make_outcome(ACT_RECONNECT, '0, '0, '0, '0));
                    end
                end
            end
            default:
            begin
                if (mdl_phase == PH_WAIT)
                begin
                    used = (eff > mdl_tries_left) ? eff - mdl_tries_left : 5'd0;
                    mdl_phase = PH_IDLE;
                    step_out.insert(step_out.size(),
                                    make_outcome(ACT_REPLY, '0, r, used[3:0], mdl_total));
                end
            end
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].fin = 1'b1;
    endtask

    task automatic offer_event(input kind_t k, input logic [31:0] p, input logic ok,
                               input logic [31:0] r);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        payload    <= p;
        send_ok    <= ok;
        reply_data <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_QUEUE_LEN: lim_qlen = val[4:0];
            CFG_MAX_RETRIES:   lim_retries = val[3:0];
            CFG_TIMEOUT_TICKS: lim_timeout = val;
            default: ;
        endcase
    endtask

    task automatic add_event(input kind_t k, input logic [31:0] p, input logic ok,
                             input logic [31:0] r, input logic [1:0] mode,
                             input action_t a, input logic [31:0] want_pay);
        script_row_t row;
        row = '0;
        row.k = k;
        row.pay = p;
        row.ok = ok;
        row.rep = r;
        row.mode = mode;
        row.act = a;
        row.want_pay = want_pay;
        script.insert(script.size(), row);
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [15:0] val);
        script_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.val = val;
        script.insert(script.size(), row);
    endtask

    initial
    begin
        int        hold;
        outcome_t  want;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                if (pending.size() == 0)
                    log_fault($sformatf("unexpected result, action %0d", action));
                else
                begin
                    want = pending.pop_front();
                    check_field("action", 32'(action), 32'(want.act));
                    check_field("out_payload", out_payload, want.pay);
                    check_field("out_reply", out_reply, want.rep);
                    check_field("tries_used", 32'(tries_used), 32'(want.tries));
                    check_field("elapsed_ticks", 32'(elapsed_ticks), 32'(want.elapsed));
                    check_field("last", 32'(last), 32'(want.fin));
                end
                hold = recv_calm ? 0 : $urandom_range(0, 9);
                if (hold > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        script_row_t row;
        outcome_t    w;
        kind_t       k;
        logic [31:0] p;
        logic [31:0] r;
        logic        ok;
        int          roll;
        int          enq_pct;
        int          sent;
        int          waited;

        faults = 0;
        send_calm = 1'b0;
        recv_calm = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        kind       <= KIND_ENQ;
        payload    <= '0;
        send_ok    <= 1'b0;
        reply_data <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_MAX_QUEUE_LEN;
        cfg_data   <= '0;

        lim_qlen = MAX_QUEUE_LEN_RST;
        lim_retries = MAX_RETRIES_RST;
        lim_timeout = TIMEOUT_TICKS_RST;
        mdl_phase = PH_IDLE;
        mdl_tries_left = '0;
        mdl_wait = '0;
        mdl_total = '0;
        mdl_current = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_event(KIND_TICK,   0, 1'b0, 0, CHK_NONE, ACT_ACCEPTED, 0);
        add_event(KIND_STATUS, 0, 1'b1, 0, CHK_NONE, ACT_ACCEPTED, 0);
        add_event(KIND_REPLY,  0, 1'b0, 32'hFFFF_FFFF, CHK_NONE, ACT_ACCEPTED, 0);
        add_event(KIND_ENQ, 32'h0000_0000, 1'b0, 0, CHK_TYPED, ACT_ACCEPTED, 0);
        add_event(KIND_ENQ, 32'hFFFF_FFFF, 1'b1, 0, CHK_TYPED, ACT_ACCEPTED, 0);
        add_event(KIND_TICK,   0, 1'b0, 0, CHK_TYPED, ACT_SEND_REQ, 32'h0000_0000);
        add_event(KIND_TICK,   0, 1'b0, 0, CHK_NONE, ACT_ACCEPTED, 0);
        add_event(KIND_REPLY,  0, 1'b0, 32'h5A5A_5A5A, CHK_NONE, ACT_ACCEPTED, 0);
        add_event(KIND_ENQ, 32'h1234_5678, 1'b0, 0, CHK_TYPED, ACT_ACCEPTED, 0);
        add_event(KIND_STATUS, 0, 1'b0, 0, CHK_TYPED, ACT_RECONNECT, 0);
        add_event(KIND_TICK,   0, 1'b0, 0, CHK_TYPED, ACT_SEND_REQ, 32'hFFFF_FFFF);
        add_event(KIND_STATUS, 0, 1'b1, 0, CHK_TYPED, ACT_SENT, 0);
        add_event(KIND_STATUS, 0, 1'b0, 0, CHK_NONE, ACT_ACCEPTED, 0);
        add_event(KIND_TICK,   0, 1'b0, 0, CHK_NONE, ACT_ACCEPTED, 0);
        add_event(KIND_REPLY,  0, 1'b0, 32'h0000_0000, CHK_MODEL, ACT_ACCEPTED, 0);
        add_cfg(CFG_TIMEOUT_TICKS, 16'd0);
        add_cfg(CFG_MAX_RETRIES, 16'd2);
        add_event(KIND_TICK,   0, 1'b0, 0, CHK_TYPED, ACT_SEND_REQ, 32'h1234_5678);
        add_event(KIND_STATUS, 0, 1'b1, 0, CHK_TYPED, ACT_SENT, 0);
        add_event(KIND_TICK,   0, 1'b0, 0, CHK_MODEL, ACT_ACCEPTED, 0);
        add_event(KIND_STATUS, 0, 1'b1, 0, CHK_TYPED, ACT_SENT, 0);
        add_event(KIND_TICK,   0, 1'b0, 0, CHK_MODEL, ACT_ACCEPTED, 0);
        add_cfg(CFG_MAX_QUEUE_LEN, 16'd0);
        add_event(KIND_ENQ, 32'hDEAD_BEEF, 1'b0, 0, CHK_TYPED, ACT_DROPPED, 0);
        add_cfg(CFG_MAX_QUEUE_LEN, 16'd1);
        add_event(KIND_ENQ, 32'h8000_0001, 1'b0, 0, CHK_TYPED, ACT_ACCEPTED, 0);
        add_event(KIND_ENQ, 32'h7FFF_FFFE, 1'b0, 0, CHK_TYPED, ACT_DROPPED, 0);
        add_cfg(CFG_MAX_RETRIES, 16'd0);
        add_event(KIND_TICK,   0, 1'b0, 0, CHK_TYPED, ACT_SEND_REQ, 32'h8000_0001);
        add_event(KIND_STATUS, 0, 1'b1, 0, CHK_TYPED, ACT_SENT, 0);
        add_event(KIND_REPLY,  0, 1'b0, 32'hFFFF_FFFF, CHK_MODEL, ACT_ACCEPTED, 0);

        foreach (script[i])
        begin
            row = script[i];
            if (row.is_cfg)
            begin
                settle_block();
                write_reg(row.idx, row.val);
            end
            else
            begin
                offer_event(row.k, row.pay, row.ok, row.rep);
                predict_event(row.k, row.pay, row.ok, row.rep);
                if (row.mode == CHK_TYPED)
                begin
                    w = make_outcome(row.act, row.want_pay, '0, '0, '0);
                    w.fin = 1'b1;
                    pending.insert(pending.size(), w);
                end
                else if (row.mode == CHK_MODEL)
                    foreach (step_out[j]) pending.insert(pending.size(), step_out[j]);
            end
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            settle_block();
            case (ph)
                0:
                begin
                    write_reg(CFG_MAX_QUEUE_LEN, 16'd16);
                    write_reg(CFG_MAX_RETRIES, 16'd1);
                    write_reg(CFG_TIMEOUT_TICKS, 16'd0);
                end
                1:
                begin
                    write_reg(CFG_MAX_QUEUE_LEN, 16'd31);
                    write_reg(CFG_MAX_RETRIES, 16'd15);
                    write_reg(CFG_TIMEOUT_TICKS, 16'd3);
                end
                2:
                begin
                    write_reg(CFG_MAX_QUEUE_LEN, 16'd0);
                    write_reg(CFG_MAX_RETRIES, 16'd0);
                    write_reg(CFG_TIMEOUT_TICKS, 16'd1);
                end
                3:
                begin
                    write_reg(CFG_MAX_QUEUE_LEN, 16'd1);
                    write_reg(CFG_MAX_RETRIES, 16'd2);
                    write_reg(CFG_TIMEOUT_TICKS, 16'd65535);
                end
                default:
                begin
                    write_reg(CFG_MAX_QUEUE_LEN, 16'($urandom_range(0, 31)));
                    write_reg(CFG_MAX_RETRIES, 16'($urandom_range(0, 15)));
                    if ($urandom_range(0, 3) == 0)
                        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(20, 1000)));
                    else
                        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(0, 12)));
                end
            endcase
            send_calm = (ph == 1 || ph == 3) ? 1'b1 : ($urandom_range(0, 3) == 0);
            recv_calm = (ph == 1 || ph == 2) ? 1'b1 : ($urandom_range(0, 3) == 0);
            enq_pct = $urandom_range(20, 70);
            sent = 0;
            while (sent < 240)
            begin
                roll = $urandom_range(0, 99);
                case (mdl_phase)
                    PH_IDLE:
                        k = (roll < enq_pct) ? KIND_ENQ : (roll < 92) ? KIND_TICK :
                            (roll < 96) ? KIND_STATUS : KIND_REPLY;
                    PH_SEND:
                        k = (roll < 70) ? KIND_STATUS : (roll < 85) ? KIND_TICK :
                            (roll < 93) ? KIND_ENQ : KIND_REPLY;
                    default:
                        k = (roll < 25) ? KIND_REPLY : (roll < 85) ? KIND_TICK :
                            (roll < 95) ? KIND_ENQ : KIND_STATUS;
                endcase
                p = $urandom;
                r = $urandom;
                ok = ($urandom_range(0, 99) < 75);
                if (ph >= 4 && $urandom_range(0, 63) == 0)
                    send_calm = ~send_calm;
                offer_event(k, p, ok, r);
                predict_event(k, p, ok, r);
                foreach (step_out[j]) pending.insert(pending.size(), step_out[j]);
                sent++;
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (pending.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending.size() != 0)
            log_fault($sformatf("%0d results never arrived", pending.size()));

        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> request_retry_queue_controller.f
+incdir+hw/rtl
hw/rtl/rrq_pkg.sv
hw/rtl/rrq_cell.sv
hw/rtl/rrq_out_fifo.sv
hw/rtl/request_retry_queue_controller.sv
bench/tb_top.sv
